### hw/rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared widths, register indexes and conversion constants for the YUV 4:2:0
// to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    localparam int CHAN_W      = 8;
    localparam int CHROMA_S_W  = 9;
    localparam int PAIRS_REG_W = 11;
    localparam int ROWS_REG_W  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int SUM_W       = 19;

    localparam logic [PAIRS_REG_W-1:0] PAIRS_RESET = 11'd320;
    localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 13'd480;

    // Chroma offset and 8.8 fixed-point coefficients.
    localparam logic signed [CHROMA_S_W-1:0] CHROMA_OFFSET = 9'sd128;
    localparam logic signed [SUM_W-1:0]      COEF_RV       = 19'sd359;
    localparam logic signed [SUM_W-1:0]      COEF_GU       = 19'sd88;
    localparam logic signed [SUM_W-1:0]      COEF_GV       = 19'sd183;
    localparam logic signed [SUM_W-1:0]      COEF_BU       = 19'sd454;
    localparam logic [CHAN_W-1:0]            CHAN_MAX      = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAIRS_PER_ROW  = 1'b0,
        REG_ROWS_PER_FRAME = 1'b1
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0]                chan_t;
    typedef logic signed [CHROMA_S_W-1:0]     chroma_s_t;

endpackage

`default_nettype wire

### hw/rtl/y2r_pixel.sv
// ----------------------------------------------------------------------------
// y2r_pixel
// Converts one luma sample with centered chroma to a clamped RGB triple.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_pixel
(
    input  wire  y2r_pkg::chan_t     luma,
    input  wire  y2r_pkg::chroma_s_t u,
    input  wire  y2r_pkg::chroma_s_t v,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue
);

    logic signed [y2r_pkg::SUM_W-1:0] yy;
    logic signed [y2r_pkg::SUM_W-1:0] u_ext;
    logic signed [y2r_pkg::SUM_W-1:0] v_ext;
    logic signed [y2r_pkg::SUM_W-1:0] r_sum;
    logic signed [y2r_pkg::SUM_W-1:0] g_sum;
    logic signed [y2r_pkg::SUM_W-1:0] b_sum;

    // Floor division by 256 and saturation to the 8-bit range.
    function automatic y2r_pkg::chan_t clamp_channel(input logic signed [18:0] s);
        logic signed [10:0] q;
        q = s[18:8];
        if (q < 11'sd0)
        begin
            return '0;
        end
        else if (q > 11'sd255)
        begin
            return y2r_pkg::CHAN_MAX;
        end
        else
        begin
            return q[7:0];
        end
    endfunction

    assign yy    = signed'({3'b000, luma, 8'b0000_0000});
    assign u_ext = y2r_pkg::SUM_W'(u);
    assign v_ext = y2r_pkg::SUM_W'(v);

    assign r_sum = yy + v_ext * y2r_pkg::COEF_RV;
    assign g_sum = yy - (u_ext * y2r_pkg::COEF_GU + v_ext * y2r_pkg::COEF_GV);
    assign b_sum = yy + u_ext * y2r_pkg::COEF_BU;

    assign red   = clamp_channel(r_sum);
    assign green = clamp_channel(g_sum);
    assign blue  = clamp_channel(b_sum);

endmodule

`default_nettype wire

### hw/rtl/yuv420_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter
// Raster-order YUV 4:2:0 to RGB conversion, two pixels per transfer.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock and gives one RGB pair per clock
// while the output is not stalled. A pair accepted at the input is held in
// the stage-one registers, then in the output register, from which its output
// transfer takes place; an output stall holds it there. The chroma line
// buffer is read at the input transfer, so the read data lines up with the
// input register. On even rows the pair's chroma is used and stored at the
// current column; on odd rows the stored chroma is used and the chroma
// inputs are ignored. The line buffer has no clearing pass, so the first
// row of use must be even. Configuration must be written only while no
// transfer is in flight; the block does not enforce this. A counter at or
// past a newly written row or frame length ends the row or frame at its
// next pair.
`default_nettype none

module yuv420_to_rgb_converter
#(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 4096
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_write,
    input  wire  [0:0]  cfg_index,
    input  wire  [12:0] cfg_data,

    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  luma_first,
    input  wire  [7:0]  luma_second,
    input  wire  [7:0]  chroma_blue,
    input  wire  [7:0]  chroma_red,

    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  red_first,
    output logic [7:0]  green_first,
    output logic [7:0]  blue_first,
    output logic [7:0]  red_second,
    output logic [7:0]  green_second,
    output logic [7:0]  blue_second,
    output logic        row_end,
    output logic        frame_end
);

    localparam int COL_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int PCMP_W = (y2r_pkg::PAIRS_REG_W > COL_W + 1) ?
                            y2r_pkg::PAIRS_REG_W : COL_W + 1;
    localparam int RCMP_W = (y2r_pkg::ROWS_REG_W > ROW_W + 1) ?
                            y2r_pkg::ROWS_REG_W : ROW_W + 1;

    // Configuration registers.
    logic [y2r_pkg::PAIRS_REG_W-1:0] pairs_reg;
    logic [y2r_pkg::ROWS_REG_W-1:0]  rows_reg;

    // Position counters.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;
    logic             last_col;
    logic             last_row;

    // Chroma line buffer.
    logic [15:0] chroma_mem [MAX_PAIRS];
    logic [15:0] rd_data_reg;

    // Stage one.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_luma_first_reg;
    logic [7:0]  s1_luma_second_reg;
    logic [7:0]  s1_cb_reg;
    logic [7:0]  s1_cr_reg;
    logic        s1_odd_reg;
    logic        s1_row_end_reg;
    logic        s1_frame_end_reg;

    // Output stage.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  red_first_reg;
    logic [7:0]  green_first_reg;
    logic [7:0]  blue_first_reg;
    logic [7:0]  red_second_reg;
    logic [7:0]  green_second_reg;
    logic [7:0]  blue_second_reg;
    logic        row_end_reg;
    logic        frame_end_reg;

    logic        out_free;
    logic        s1_load;
    logic        in_accept;
    logic        row_odd;

    logic [7:0]          cb_sel;
    logic [7:0]          cr_sel;
    y2r_pkg::chroma_s_t  u_c;
    y2r_pkg::chroma_s_t  v_c;
    logic [7:0]          r0;
    logic [7:0]          g0;
    logic [7:0]          b0;
    logic [7:0]          r1;
    logic [7:0]          g1;
    logic [7:0]          b1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= y2r_pkg::PAIRS_RESET;
            rows_reg  <= y2r_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (y2r_pkg::cfg_reg_t'(cfg_index))
                y2r_pkg::REG_PAIRS_PER_ROW:
                begin
                    pairs_reg <= cfg_data[y2r_pkg::PAIRS_REG_W-1:0];
                end
                y2r_pkg::REG_ROWS_PER_FRAME:
                begin
                    rows_reg <= cfg_data[y2r_pkg::ROWS_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A zero length acts as one and an oversized length as the maximum.
    always_comb
    begin
        if (pairs_reg == '0)
        begin
            last_col_idx = '0;
        end
        else if (PCMP_W'(pairs_reg) > PCMP_W'(MAX_PAIRS))
        begin
            last_col_idx = COL_W'(MAX_PAIRS - 1);
        end
        else
        begin
            last_col_idx = COL_W'(PCMP_W'(pairs_reg) - PCMP_W'(1));
        end

        if (rows_reg == '0)
        begin
            last_row_idx = '0;
        end
        else if (RCMP_W'(rows_reg) > RCMP_W'(MAX_ROWS))
        begin
            last_row_idx = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row_idx = ROW_W'(RCMP_W'(rows_reg) - RCMP_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_load   = !s1_valid_reg || out_free;
    assign in_stall  = !s1_load;
    assign in_accept = in_valid && s1_load;

    assign last_col = col_reg >= last_col_idx;
    assign last_row = row_reg >= last_row_idx;
    assign row_odd  = row_reg[0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: written on even rows, read on odd rows.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept && !row_odd)
        begin
            chroma_mem[col_reg] <= {chroma_red, chroma_blue};
        end
        if (in_accept && row_odd)
        begin
            rd_data_reg <= chroma_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage one payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_luma_first_reg  <= luma_first;
            s1_luma_second_reg <= luma_second;
            s1_cb_reg          <= chroma_blue;
            s1_cr_reg          <= chroma_red;
            s1_odd_reg         <= row_odd;
            s1_row_end_reg     <= last_col;
            s1_frame_end_reg   <= last_col && last_row;
        end
    end

    assign cb_sel = s1_odd_reg ? rd_data_reg[7:0]  : s1_cb_reg;
    assign cr_sel = s1_odd_reg ? rd_data_reg[15:8] : s1_cr_reg;
    assign u_c    = signed'({1'b0, cb_sel}) - y2r_pkg::CHROMA_OFFSET;
    assign v_c    = signed'({1'b0, cr_sel}) - y2r_pkg::CHROMA_OFFSET;

    y2r_pixel u_pixel_first
    (
        .luma  (s1_luma_first_reg),
        .u     (u_c),
        .v     (v_c),
        .red   (r0),
        .green (g0),
        .blue  (b0)
    );

    y2r_pixel u_pixel_second
    (
        .luma  (s1_luma_second_reg),
        .u     (u_c),
        .v     (v_c),
        .red   (r1),
        .green (g1),
        .blue  (b1)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            red_first_reg    <= r0;
            green_first_reg  <= g0;
            blue_first_reg   <= b0;
            red_second_reg   <= r1;
            green_second_reg <= g1;
            blue_second_reg  <= b1;
            row_end_reg      <= s1_row_end_reg;
            frame_end_reg    <= s1_frame_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_first    = red_first_reg;
    assign green_first  = green_first_reg;
    assign blue_first   = blue_first_reg;
    assign red_second   = red_second_reg;
    assign green_second = green_second_reg;
    assign blue_second  = blue_second_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;

`ifndef SYNTHESIS
    // A stalled output with a full first stage must hold off new input.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && s1_valid_reg) |-> in_stall)
        else $error("input accepted while the pipeline is full");

    // The end of a frame is always also the end of a row.
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!frame_end_reg || row_end_reg))
        else $error("frame end without row end");

    // The pair that ends a row returns the column counter to zero.
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_col) |=> (col_reg == '0))
        else $error("column counter did not wrap at row end");

    // A first-stage item moves into a free output register.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("pair lost between stages");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams pixel pairs through the YUV 4:2:0 to RGB converter under random
// idle and stall bursts. A scoreboard predicts every RGB pair and the
// row and frame end flags, and checks each output transfer in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAIRS      = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 10;
    localparam int NUM_DIRECTED   = 24;

    typedef struct packed {
        y2r_pkg::chan_t red_first;
        y2r_pkg::chan_t green_first;
        y2r_pkg::chan_t blue_first;
        y2r_pkg::chan_t red_second;
        y2r_pkg::chan_t green_second;
        y2r_pkg::chan_t blue_second;
        logic           row_end;
        logic           frame_end;
    } rgb_pair_t;

    // Predicts the converter output for every accepted pair and holds the
    // expected pairs in arrival order.
    class rgb_scoreboard;
        logic [y2r_pkg::PAIRS_REG_W-1:0] pairs_reg;
        logic [y2r_pkg::ROWS_REG_W-1:0]  rows_reg;
        int                              column;
        int                              row;
        logic [15:0]                     chroma_line [MAX_PAIRS];
        rgb_pair_t                       expected_pairs [$];
        int                              errors;

        function new();
            pairs_reg = y2r_pkg::PAIRS_RESET;
            rows_reg  = y2r_pkg::ROWS_RESET;
            column    = 0;
            row       = 0;
            errors    = 0;
        endfunction

        function void set_reg(y2r_pkg::cfg_reg_t idx,
                              logic [y2r_pkg::CFG_DATA_W-1:0] value);
            if (idx == y2r_pkg::REG_PAIRS_PER_ROW)
                pairs_reg = value[y2r_pkg::PAIRS_REG_W-1:0];
            else
                rows_reg = value[y2r_pkg::ROWS_REG_W-1:0];
        endfunction

        function int effective_count(int value, int max_value);
            if (value == 0)
                return 1;
            if (value > max_value)
                return max_value;
            return value;
        endfunction

        // Floor of the 8.8 sum, clamped to one byte.
        function y2r_pkg::chan_t to_channel(int sum);
            int q;
            q = sum >>> 8;
            if (q < 0)
                return 8'd0;
            if (q > 255)
                return 8'd255;
            return y2r_pkg::chan_t'(q);
        endfunction

        function void note_input(y2r_pkg::chan_t y1, y2r_pkg::chan_t y2,
                                 y2r_pkg::chan_t u, y2r_pkg::chan_t v);
            int        pairs;
            int        rows;
            int        slot;
            int        cb;
            int        cr;
            int        yy1;
            int        yy2;
            bit        last_col;
            bit        last_row;
            rgb_pair_t pair;
            pairs = effective_count(int'(pairs_reg), MAX_PAIRS);
            rows  = effective_count(int'(rows_reg), MAX_ROWS);
            slot  = (column >= MAX_PAIRS) ? MAX_PAIRS - 1 : column;
            if (row % 2 == 0)
            begin
                chroma_line[slot] = {v, u};
                cb = int'(u) - 128;
                cr = int'(v) - 128;
            end
            else
            begin
                cb = int'(chroma_line[slot][7:0]) - 128;
                cr = int'(chroma_line[slot][15:8]) - 128;
            end
            yy1 = int'(y1) * 256;
            yy2 = int'(y2) * 256;
            pair.red_first    = to_channel(yy1 + 359 * cr);
            pair.green_first  = to_channel(yy1 - (88 * cb + 183 * cr));
            pair.blue_first   = to_channel(yy1 + 454 * cb);
            pair.red_second   = to_channel(yy2 + 359 * cr);
            pair.green_second = to_channel(yy2 - (88 * cb + 183 * cr));
            pair.blue_second  = to_channel(yy2 + 454 * cb);
            last_col = column >= pairs - 1;
            last_row = row >= rows - 1;
            pair.row_end   = last_col;
            pair.frame_end = last_col && last_row;
            expected_pairs.push_back(pair);
            if (last_col)
            begin
                column = 0;
                row    = last_row ? 0 : row + 1;
            end
            else
            begin
                column = column + 1;
            end
        endfunction

        function void check_result(rgb_pair_t actual);
            rgb_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output transfer: rgb %0d,%0d,%0d %0d,%0d,%0d",
                             actual.red_first, actual.green_first, actual.blue_first,
                             actual.red_second, actual.green_second, actual.blue_second);
                return;
            end
            want = expected_pairs.pop_front();
            if (actual !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected rgb %0d,%0d,%0d %0d,%0d,%0d ends %b%b",
                             want.red_first, want.green_first, want.blue_first,
                             want.red_second, want.green_second, want.blue_second,
                             want.row_end, want.frame_end);
                    $display("          actual   rgb %0d,%0d,%0d %0d,%0d,%0d ends %b%b",
                             actual.red_first, actual.green_first, actual.blue_first,
                             actual.red_second, actual.green_second, actual.blue_second,
                             actual.row_end, actual.frame_end);
                end
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function bit on_odd_row();
            return row % 2 == 1;
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [y2r_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [y2r_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    y2r_pkg::chan_t                  luma_first;
    y2r_pkg::chan_t                  luma_second;
    y2r_pkg::chan_t                  chroma_blue;
    y2r_pkg::chan_t                  chroma_red;
    logic                            out_valid;
    logic                            out_stall;
    y2r_pkg::chan_t                  red_first;
    y2r_pkg::chan_t                  green_first;
    y2r_pkg::chan_t                  blue_first;
    y2r_pkg::chan_t                  red_second;
    y2r_pkg::chan_t                  green_second;
    y2r_pkg::chan_t                  blue_second;
    logic                            row_end;
    logic                            frame_end;

    rgb_scoreboard                   pixel_sb;
    bit                              no_idle;
    int                              send_idle_pct;
    int                              stall_pct;
    int                              stall_left;
    int                              silent_cycles;

    yuv420_to_rgb_converter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Sends one pixel pair, with an optional idle burst ahead of it, and
    // returns at the edge where the transfer takes place.
    task automatic send_pair(input y2r_pkg::chan_t y1, input y2r_pkg::chan_t y2,
                             input y2r_pkg::chan_t u, input y2r_pkg::chan_t v);
        int gap;
        if (!no_idle && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        luma_first  <= y1;
        luma_second <= y2;
        chroma_blue <= u;
        chroma_red  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixel_sb.note_input(y1, y2, u, v);
    endtask

    task automatic send_random_pair();
        send_pair(y2r_pkg::chan_t'($urandom), y2r_pkg::chan_t'($urandom),
                  y2r_pkg::chan_t'($urandom), y2r_pkg::chan_t'($urandom));
    endtask

    // Lets every expected pair drain, then writes both size registers.
    task automatic program_size(input logic [y2r_pkg::CFG_DATA_W-1:0] pairs,
                                input logic [y2r_pkg::CFG_DATA_W-1:0] rows);
        in_valid <= 1'b0;
        while (pixel_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= y2r_pkg::REG_PAIRS_PER_ROW;
        cfg_data  <= pairs;
        @(posedge clk);
        pixel_sb.set_reg(y2r_pkg::REG_PAIRS_PER_ROW, pairs);
        cfg_index <= y2r_pkg::REG_ROWS_PER_FRAME;
        cfg_data  <= rows;
        @(posedge clk);
        pixel_sb.set_reg(y2r_pkg::REG_ROWS_PER_FRAME, rows);
        cfg_write <= 1'b0;
    endtask

    // Output side: random stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!no_idle && $urandom_range(99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(2, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pixel_sb.check_result('{red_first, green_first, blue_first, red_second,
                                    green_second, blue_second, row_end, frame_end});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            silent_cycles = 0;
        else
            silent_cycles = silent_cycles + 1;
        if (silent_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL yuv420_to_rgb_converter");
            $finish;
        end
    end

    initial
    begin
        logic [31:0]                    directed [NUM_DIRECTED];
        logic [y2r_pkg::CFG_DATA_W-1:0] phase_pairs [NUM_PHASES];
        logic [y2r_pkg::CFG_DATA_W-1:0] phase_rows [NUM_PHASES];
        int                             phase_items [NUM_PHASES];

        // Three-row frames of two pairs; chroma on odd rows is ignored.
        directed = '{32'h00FF_0000, 32'hFF00_FFFF, 32'h00FF_5AA5, 32'hFF00_1234,
                     32'h8080_8080, 32'h10EB_FF00, 32'hFFFF_00FF, 32'h0000_FF00,
                     32'h7F80_0000, 32'h01FE_FFFF, 32'hEB10_8000, 32'h40C0_0080,
                     32'h8080_10F0, 32'h00FF_F010, 32'hFF00_AA55, 32'h23DC_55AA,
                     32'hFF00_80FF, 32'h00FF_FF80, 32'h55AA_3CC3, 32'hAA55_C33C,
                     32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_7F81, 32'hFDFE_817F};
        // Zero and oversized sizes, a row cut short and a frame cut short
        // by a smaller size, then single-row frames at the end.
        phase_pairs = '{13'd1, 13'd0, 13'd4, 13'h1FFF, 13'd7,
                        13'd3, 13'd1024, 13'd5, 13'd16, 13'd2};
        phase_rows  = '{13'd1, 13'd0, 13'd2, 13'd8191, 13'd4096,
                        13'd2, 13'd0, 13'd3, 13'd5, 13'd1};
        phase_items = '{150, 100, 250, 60, 200, 200, 80, 250, 250, 200};

        pixel_sb      = new();
        no_idle       = 1'b0;
        send_idle_pct = 20;
        stall_pct     = 20;
        stall_left    = 0;
        silent_cycles = 0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = y2r_pkg::REG_PAIRS_PER_ROW;
        cfg_data      = '0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        luma_first    = '0;
        luma_second   = '0;
        chroma_blue   = '0;
        chroma_red    = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_size(13'd2, 13'd3);
        foreach (directed[i])
            send_pair(directed[i][31:24], directed[i][23:16], directed[i][15:8],
                      directed[i][7:0]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Sizes change only on an even row, so that every odd row reads
            // chroma that the row above it wrote.
            while (pixel_sb.on_odd_row())
                send_random_pair();
            program_size(phase_pairs[p], phase_rows[p]);
            no_idle = (p == NUM_PHASES - 1);
            send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            stall_pct     = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            for (int n = 0; n < phase_items[p]; n++)
                send_random_pair();
        end

        in_valid <= 1'b0;
        while (pixel_sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (pixel_sb.errors == 0 && pixel_sb.pending() == 0)
            $display("PASS yuv420_to_rgb_converter");
        else
            $display("FAIL yuv420_to_rgb_converter");
        $finish;
    end

endmodule

### sim.f
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_pixel.sv
hw/rtl/yuv420_to_rgb_converter.sv
verif/testbench.sv
